// ===== sv/kalman_angle_filter_top_macros.svh =====
// Assertion macros for the angle filter
`ifndef KALMAN_ANGLE_FILTER_TOP_MACROS_SVH
`define KALMAN_ANGLE_FILTER_TOP_MACROS_SVH
// implication check under synchronous reset
`define KAF_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication check
`define KAF_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/kaf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_pkg
// Shared types and constants of the angle filter.
// ----------------------------------------------------------------------------
package kaf_pkg;
  localparam int AXES = 3;
  localparam int AXIS_W = 2;
  localparam int IDX_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;

  localparam logic [1:0] REG_TIME_STEP = 2'd0;
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd1;
  localparam logic [1:0] REG_BIAS_NOISE = 2'd2;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd3;

  // sequencer steps; each but S_LOAD and S_HOLD issues one datapath operation (S_IDLE only on a transfer)
  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_RATE, S_MANG, S_ANG, S_D, S_M00, S_M01, S_M10, S_M11,
    S_PRED, S_E, S_DIV0, S_DIV0W, S_DIV1, S_DIV1W, S_MK0, S_MK1, S_MK2, S_MK3,
    S_MK4, S_MK5, S_UPD, S_OUT, S_HOLD
  } kaf_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_RATE, OP_MANG, OP_ANG, OP_D, OP_M00, OP_M01, OP_M10,
    OP_M11, OP_PRED, OP_E, OP_DIV0, OP_DIV0W, OP_DIV1, OP_DIV1W, OP_MK0, OP_MK1,
    OP_MK2, OP_MK3, OP_MK4, OP_MK5, OP_UPD, OP_OUT
  } kaf_op_t;

  typedef struct packed {
    kaf_op_t op;
  } kaf_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic axis_ok;
  } kaf_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (x < -66'sd2147483648) r = 32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction
endpackage

// ===== sv/kalman_angle_filter_top.sv =====
// Gain divisions run in a shared restoring divider; an out-of-range axis skips
// prediction, division and update. One item in flight: no new input transfer until
// the result is taken. Reset (rst_n low, synchronous): registers to defaults,
// angle and bias zero, covariance identity per axis.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_filter_top
// Two-state angle and gyro bias filter for several axes.
// ----------------------------------------------------------------------------
`include "kalman_angle_filter_top_macros.svh"
module kalman_angle_filter_top import kaf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_axis,
  input  logic signed [31:0] in_accel_angle,
  input  logic signed [31:0] in_gyro_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_angle_centi,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_corrected_rate,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  kaf_cmd_t cmd;
  kaf_sts_t sts;

  assign cfg_ready = 1'b1;

  kaf_control u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  kaf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_axis(in_axis), .in_accel_angle(in_accel_angle), .in_gyro_rate(in_gyro_rate),
    .cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_angle_centi(out_angle_centi), .out_angle_estimate(out_angle_estimate),
    .out_corrected_rate(out_corrected_rate)
  );

  // no new transfer while a result is pending
  `KAF_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  // result holds until taken
  `KAF_ASSERT_NXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid)
  // accepting an item starts the sequence
  `KAF_ASSERT_NXT(a_start, clk, rst_n, in_valid && in_ready, !in_ready && !out_valid)
endmodule

// ===== sv/kaf_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_divider
// Restoring divider, one quotient bit a cycle: (num << 30) / den, both positive.
// ----------------------------------------------------------------------------
module kaf_divider import kaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [32:0] den,
  output logic        busy,
  output logic [61:0] quot
);
  logic [61:0] dividend_r, dividend_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [33:0] trial;
  logic        busy_r, busy_nxt;

  assign trial = {rem_r[32:0], dividend_r[61]};

  always_comb begin
    dividend_nxt = dividend_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      dividend_nxt = {num, 30'd0};
      rem_nxt = '0;
      cnt_nxt = 6'd62;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        dividend_nxt = {dividend_r[60:0], 1'b1};
      end else begin
        rem_nxt = trial;
        dividend_nxt = {dividend_r[60:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    dividend_r <= dividend_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign busy = busy_r;
  assign quot = dividend_r;
endmodule

// ===== sv/kaf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_datapath
// Per-axis state, shared multiplier, divider and output register.
// ----------------------------------------------------------------------------
module kaf_datapath import kaf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  kaf_cmd_t           cmd,
  output kaf_sts_t           sts,
  input  logic [AXIS_W-1:0]  in_axis,
  input  logic signed [31:0] in_accel_angle,
  input  logic signed [31:0] in_gyro_rate,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [15:0] out_angle_centi,
  output logic signed [31:0] out_angle_estimate,
  output logic signed [31:0] out_corrected_rate
);
  logic [31:0] ts_r, qa_r, qb_r, rm_r;
  logic signed [31:0] ang_st_r [AXES];
  logic signed [31:0] bias_st_r [AXES];
  logic signed [31:0] p_st_r [AXES][4];

  logic [AXIS_W-1:0]  axis_r;
  logic signed [31:0] acc_r, gyro_r, ang_r, bias_r, rate_r, err_r;
  logic signed [31:0] p0_r, p1_r, p2_r, p3_r, d0_r, d1_r, k0_r, k1_r;
  logic signed [31:0] q0_r, q1_r, q2_r, q3_r;
  logic signed [65:0] prod_r;
  logic signed [33:0] e_r;
  logic signed [15:0] centi_r;
  logic signed [31:0] oang_r, orate_r;

  logic [IDX_W-1:0] ix;
  logic             axis_ok;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod, shf;
  logic div_start, div_busy;
  logic [61:0] quot;
  logic signed [31:0] ksat;
  logic signed [31:0] new_rate;
  logic signed [47:0] c100;
  logic signed [47:0] cdiv;
  logic neg_r;
  logic signed [31:0] divnum_s;
  logic [31:0] mag;
  logic signed [63:0] qs;

  assign axis_ok = ({{(32-AXIS_W){1'b0}}, axis_r} < AXES);
  assign ix = axis_r[IDX_W-1:0];
  assign sts.axis_ok = axis_ok;
  assign sts.div_busy = div_busy;

  // operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_MANG: begin ma = 33'(rate_r); mb = {1'b0, ts_r}; end
      OP_M00:  begin ma = 33'(d0_r); mb = {1'b0, ts_r}; end
      OP_M01, OP_M10: begin ma = 33'(d1_r); mb = {1'b0, ts_r}; end
      OP_M11:  begin ma = {1'b0, qb_r}; mb = {1'b0, ts_r}; end
      OP_MK0:  begin ma = 33'(q0_r); mb = 33'(k0_r); end
      OP_MK1:  begin ma = 33'(q1_r); mb = 33'(k0_r); end
      OP_MK2:  begin ma = 33'(q0_r); mb = 33'(k1_r); end
      OP_MK3:  begin ma = 33'(q1_r); mb = 33'(k1_r); end
      OP_MK4:  begin ma = 33'(err_r); mb = 33'(k0_r); end
      OP_MK5:  begin ma = 33'(err_r); mb = 33'(k1_r); end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign mprod = ma * mb;
  assign shf = prod_r >>> 30;

  assign div_start = (cmd.op == OP_DIV0) || (cmd.op == OP_DIV1);
  // gains that fold sign: num taken as magnitude, sign restored after
  assign divnum_s = (cmd.op == OP_DIV0) ? q0_r : q2_r;
  assign mag = divnum_s[31] ? 32'(-divnum_s) : divnum_s;

  kaf_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(mag), .den(e_r[32:0]), .busy(div_busy), .quot(quot)
  );

  assign qs = neg_r ? -$signed({2'b0, quot}) : $signed({2'b0, quot});
  assign ksat = (e_r <= 0) ? 32'sd0 : sat32(66'(qs));

  assign new_rate = sat32(66'(gyro_r) - 66'(bias_r));
  assign c100 = 48'(ang_r) * 48'sd100;
  assign cdiv = c100 / 48'sd65536;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r <= 32'd5368709;
      qa_r <= 32'd1073742;
      qb_r <= 32'd3221225;
      rm_r <= 32'd536870912;
      for (int i = 0; i < AXES; i++) begin
        ang_st_r[i] <= '0;
        bias_st_r[i] <= '0;
        p_st_r[i][0] <= Q30_ONE;
        p_st_r[i][1] <= '0;
        p_st_r[i][2] <= '0;
        p_st_r[i][3] <= Q30_ONE;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIME_STEP:   ts_r <= cfg_data;
          REG_ANGLE_NOISE: qa_r <= cfg_data;
          REG_BIAS_NOISE:  qb_r <= cfg_data;
          REG_MEAS_NOISE:  rm_r <= cfg_data;
        endcase
      end
      if (cmd.op == OP_UPD && axis_ok) begin
        ang_st_r[ix] <= ang_r;
        bias_st_r[ix] <= sat32(66'(bias_r) + shf);
        p_st_r[ix][0] <= p0_r;
        p_st_r[ix][1] <= p1_r;
        p_st_r[ix][2] <= p2_r;
        p_st_r[ix][3] <= p3_r;
      end
    end
    prod_r <= mprod;
    unique case (cmd.op)
      OP_LOAD: begin
        axis_r <= in_axis;
        acc_r <= in_accel_angle;
        gyro_r <= in_gyro_rate;
      end
      OP_RATE: begin
        ang_r <= ang_st_r[ix];
        bias_r <= bias_st_r[ix];
        p0_r <= p_st_r[ix][0];
        p1_r <= p_st_r[ix][1];
        p2_r <= p_st_r[ix][2];
        p3_r <= p_st_r[ix][3];
        rate_r <= sat32(66'(gyro_r) - 66'(bias_st_r[ix]));
      end
      OP_ANG: ang_r <= sat32(66'(ang_r) + shf);
      OP_D: begin
        d0_r <= sat32(66'($signed({1'b0, qa_r})) - 66'(p1_r) - 66'(p2_r));
        d1_r <= sat32(-66'(p3_r));
      end
      OP_M01: q0_r <= sat32(66'(p0_r) + shf);
      OP_M10: q1_r <= sat32(66'(p1_r) + shf);
      OP_M11: q2_r <= sat32(66'(p2_r) + shf);
      OP_PRED: begin
        q3_r <= sat32(66'(p3_r) + shf);
        err_r <= sat32(66'(acc_r) - 66'(ang_r));
      end
      OP_E: e_r <= 34'($signed({1'b0, rm_r})) + 34'(q0_r);
      OP_DIV0, OP_DIV1: neg_r <= divnum_s[31];
      OP_DIV0W: if (!div_busy) k0_r <= ksat;
      OP_DIV1W: if (!div_busy) k1_r <= ksat;
      OP_MK1: p0_r <= sat32(66'(q0_r) - shf);
      OP_MK2: p1_r <= sat32(66'(q1_r) - shf);
      OP_MK3: p2_r <= sat32(66'(q2_r) - shf);
      OP_MK4: p3_r <= sat32(66'(q3_r) - shf);
      OP_MK5: ang_r <= sat32(66'(ang_r) + shf);
      OP_UPD: bias_r <= sat32(66'(bias_r) + shf);
      OP_OUT: begin
        if (axis_ok) begin
          centi_r <= (cdiv > 48'sd32767) ? 16'sh7FFF :
                     (cdiv < -48'sd32768) ? 16'sh8000 : cdiv[15:0];
          oang_r <= ang_r;
          orate_r <= new_rate;
        end else begin
          centi_r <= '0;
          oang_r <= '0;
          orate_r <= '0;
        end
      end
      default: ;
    endcase
  end

  assign out_angle_centi = centi_r;
  assign out_angle_estimate = oang_r;
  assign out_corrected_rate = orate_r;
endmodule

// ===== sv/kaf_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_control
// Sequencer: walks one item through prediction, gain division and update; an invalid axis skips to output.
// ----------------------------------------------------------------------------
module kaf_control import kaf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  kaf_sts_t sts,
  output kaf_cmd_t cmd
);
  kaf_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_RATE;
      S_RATE:  state_nxt = sts.axis_ok ? S_MANG : S_OUT;
      S_MANG:  state_nxt = S_ANG;
      S_ANG:   state_nxt = S_D;
      S_D:     state_nxt = S_M00;
      S_M00:   state_nxt = S_M01;
      S_M01:   state_nxt = S_M10;
      S_M10:   state_nxt = S_M11;
      S_M11:   state_nxt = S_PRED;
      S_PRED:  state_nxt = S_E;
      S_E:     state_nxt = S_DIV0;
      S_DIV0:  state_nxt = S_DIV0W;
      S_DIV0W: if (!sts.div_busy) state_nxt = S_DIV1;
      S_DIV1:  state_nxt = S_DIV1W;
      S_DIV1W: if (!sts.div_busy) state_nxt = S_MK0;
      S_MK0:   state_nxt = S_MK1;
      S_MK1:   state_nxt = S_MK2;
      S_MK2:   state_nxt = S_MK3;
      S_MK3:   state_nxt = S_MK4;
      S_MK4:   state_nxt = S_MK5;
      S_MK5:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_HOLD;
      S_HOLD:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == S_IDLE);
    out_valid = (state_r == S_HOLD);
    unique case (state_r)
      // capture the payload on the transfer edge itself
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_RATE:  cmd.op = OP_RATE;
      S_MANG:  cmd.op = OP_MANG;
      S_ANG:   cmd.op = OP_ANG;
      S_D:     cmd.op = OP_D;
      S_M00:   cmd.op = OP_M00;
      S_M01:   cmd.op = OP_M01;
      S_M10:   cmd.op = OP_M10;
      S_M11:   cmd.op = OP_M11;
      S_PRED:  cmd.op = OP_PRED;
      S_E:     cmd.op = OP_E;
      S_DIV0:  cmd.op = OP_DIV0;
      S_DIV0W: cmd.op = OP_DIV0W;
      S_DIV1:  cmd.op = OP_DIV1;
      S_DIV1W: cmd.op = OP_DIV1W;
      S_MK0:   cmd.op = OP_MK0;
      S_MK1:   cmd.op = OP_MK1;
      S_MK2:   cmd.op = OP_MK2;
      S_MK3:   cmd.op = OP_MK3;
      S_MK4:   cmd.op = OP_MK4;
      S_MK5:   cmd.op = OP_MK5;
      S_UPD:   cmd.op = OP_UPD;
      S_OUT:   cmd.op = OP_OUT;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
